@@ hw/rtl/spectrum_bar_smoother_macros.svh @@
// assertion macros for the spectrum bar smoother
// expects clk and rst in the scope of the module that uses them
`ifndef SPECTRUM_BAR_SMOOTHER_MACROS_SVH
`define SPECTRUM_BAR_SMOOTHER_MACROS_SVH

// condition holds in the same cycle as its trigger
`define SBS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("spectrum bar smoother assertion failed");

// condition holds in the cycle after its trigger
`define SBS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spectrum bar smoother assertion failed");

`endif

@@ hw/rtl/sbs_pkg.sv @@
// shared types, constants and step functions of the spectrum bar smoother
// no dependencies
package sbs_pkg;

  localparam int IDX_W = 6;
  localparam int MAX_BARS_DEFAULT = 64;
  localparam logic [12:0] SCREEN_LIMIT = 13'd4096;

  localparam logic [15:0] SMOOTHING_RESET = 16'd52429;
  localparam logic [12:0] WIDTH_RESET = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [6:0] BARS_RESET = 7'd64;

  localparam logic [7:0] RED_MUL = 8'd97;
  localparam logic [7:0] GREEN_MUL = 8'd53;
  localparam logic [7:0] BLUE_MUL = 8'd29;

  // digit steps done by each iteration stage
  localparam int ITER_STAGES = 4;
  localparam int SQ_STEPS = 4;
  localparam int DIV_STEPS = 5;

  typedef enum logic [1:0] {
    REG_SMOOTHING,
    REG_WIDTH,
    REG_HEIGHT,
    REG_BARS
  } cfg_reg_t;

  // partial square root and two partial quotients
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic inr;
    logic [31:0] sq_n;
    logic [16:0] sq_rem;
    logic [15:0] sq_root;
    logic [19:0] x_num;
    logic [6:0] x_rem;
    logic [19:0] w_num;
    logic [6:0] w_rem;
  } iter_t;

  typedef struct packed {
    logic [11:0] bar_x;
    logic [12:0] bar_y;
    logic [12:0] bar_w;
    logic [12:0] bar_h;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic out_of_range;
  } res_t;

  function automatic iter_t iter_steps(iter_t s, logic [6:0] d);
    iter_t r;
    logic [18:0] sq_tmp;
    logic [18:0] sq_trial;
    logic [7:0] xt;
    logic [7:0] wt;
    r = s;
    for (int i = 0; i < SQ_STEPS; i++) begin
      sq_tmp = {r.sq_rem, r.sq_n[31:30]};
      sq_trial = {1'b0, r.sq_root, 2'b01};
      r.sq_n = {r.sq_n[29:0], 2'b00};
      if (sq_tmp >= sq_trial) begin
        sq_tmp = sq_tmp - sq_trial;
        r.sq_root = {r.sq_root[14:0], 1'b1};
      end else begin
        r.sq_root = {r.sq_root[14:0], 1'b0};
      end
      r.sq_rem = sq_tmp[16:0];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      xt = {r.x_rem, r.x_num[19]};
      wt = {r.w_rem, r.w_num[19]};
      r.x_num = {r.x_num[18:0], 1'b0};
      r.w_num = {r.w_num[18:0], 1'b0};
      if (xt >= {1'b0, d}) begin
        xt = xt - {1'b0, d};
        r.x_num[0] = 1'b1;
      end
      if (wt >= {1'b0, d}) begin
        wt = wt - {1'b0, d};
        r.w_num[0] = 1'b1;
      end
      r.x_rem = xt[6:0];
      r.w_rem = wt[6:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] colour(logic [IDX_W-1:0] idx, logic [7:0] k);
    logic [13:0] p;
    p = 14'(idx) * 14'(k);
    return p[7:0];
  endfunction

endpackage

@@ hw/rtl/sbs_in_if.sv @@
// input channel of the spectrum bar smoother: one fft bin per item
// depends on sbs_pkg
interface sbs_in_if import sbs_pkg::*; ();
  logic valid;
  logic ready;
  logic [IDX_W-1:0] bin_index;
  logic signed [15:0] real_part;
  logic signed [15:0] imag_part;

  modport source (output valid, bin_index, real_part, imag_part, input ready);
  modport sink (input valid, bin_index, real_part, imag_part, output ready);
endinterface

@@ hw/rtl/sbs_out_if.sv @@
// output channel of the spectrum bar smoother: one bar per item
// depends on sbs_pkg
interface sbs_out_if import sbs_pkg::*; ();
  logic valid;
  logic ready;
  logic [11:0] bar_x;
  logic [12:0] bar_y;
  logic [12:0] bar_w;
  logic [12:0] bar_h;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic out_of_range;

  modport source (output valid, bar_x, bar_y, bar_w, bar_h, red, green, blue,
                  out_of_range, input ready);
  modport sink (input valid, bar_x, bar_y, bar_w, bar_h, red, green, blue,
                out_of_range, output ready);
endinterface

@@ hw/rtl/sbs_cfg_if.sv @@
// register write channel of the spectrum bar smoother
// depends on sbs_pkg
interface sbs_cfg_if import sbs_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sbs_iter_stage.sv @@
// one pipeline stage of the square root and the two restoring dividers
// depends on sbs_pkg
module sbs_iter_stage import sbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic v_in,
  input  iter_t d_in,
  input  logic [6:0] divisor,
  output logic v_out,
  output iter_t d_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= iter_steps(d_in, divisor);
    end
  end

endmodule

@@ hw/rtl/sbs_level_store.sv @@
// per-bar level memory with read-modify-write, forwarding and smoothing blend
// depends on sbs_pkg
module sbs_level_store import sbs_pkg::*; #(
  parameter int MAX_BARS = MAX_BARS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic load,
  input  logic [IDX_W-1:0] idx,
  input  logic [15:0] mag,
  input  logic [15:0] sf,
  output logic [16:0] level
);

  localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  logic [16:0] mem [MAX_BARS];
  logic [MAX_BARS-1:0] vbits;

  logic [IW-1:0] idx_ext;
  logic [AW-1:0] addr_in;
  logic wr;
  logic [AW-1:0] wr_addr;
  logic [15:0] mag_q;
  logic [16:0] rd_data;
  logic rd_ok;
  logic fwd;
  logic [16:0] fwd_level;
  logic [16:0] old;
  logic [16:0] inv;
  logic [33:0] mix;
  logic [16:0] level_next;

  assign idx_ext = IW'(idx);
  assign addr_in = idx_ext[AW-1:0];

  always_comb begin
    old = fwd ? fwd_level : (rd_ok ? rd_data : 17'd0);
    inv = 17'h10000 - {1'b0, sf};
    mix = {18'd0, sf} * {17'd0, old} + {17'd0, inv} * {18'd0, mag_q};
    level_next = mix[32:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= 1'b0;
      vbits <= '0;
    end else if (en) begin
      wr <= load;
      if (wr) begin
        vbits[wr_addr] <= 1'b1;
      end
    end
  end

  // the read of the next item sees the write of this one only through fwd
  always_ff @(posedge clk) begin
    if (en) begin
      wr_addr <= addr_in;
      mag_q <= mag;
      rd_data <= mem[addr_in];
      rd_ok <= vbits[addr_in];
      fwd <= wr && (wr_addr == addr_in);
      fwd_level <= level_next;
      level <= level_next;
      if (wr) begin
        mem[wr_addr] <= level_next;
      end
    end
  end

endmodule

@@ hw/rtl/sbs_out_buf.sv @@
// two-entry output buffer so the pipeline keeps moving while a result waits
// depends on sbs_pkg and sbs_out_if
module sbs_out_buf import sbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic full,
  sbs_out_if.source out_ch
);

  logic [1:0] count;
  res_t e0;
  res_t e1;
  logic pop;

  assign pop = out_ch.valid && out_ch.ready;
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      e0 <= din;
    end else if (pop && count == 2'd2) begin
      e0 <= e1;
    end
    if (push && count == 2'd1 && !pop) begin
      e1 <= din;
    end
  end

  assign out_ch.valid = (count != 2'd0);
  assign out_ch.bar_x = e0.bar_x;
  assign out_ch.bar_y = e0.bar_y;
  assign out_ch.bar_w = e0.bar_w;
  assign out_ch.bar_h = e0.bar_h;
  assign out_ch.red = e0.red;
  assign out_ch.green = e0.green;
  assign out_ch.blue = e0.blue;
  assign out_ch.out_of_range = e0.out_of_range;

endmodule

@@ hw/rtl/spectrum_bar_smoother.sv @@
// spectrum bar smoother: one fft bin in, one bar rectangle and colour out
// depends on sbs_pkg, the channel interfaces, sbs_iter_stage, sbs_level_store,
// sbs_out_buf and spectrum_bar_smoother_macros.svh
//
// usage
// - in_ch takes one item per bin: index and q1.15 real and imaginary parts
// - out_ch gives one item per input item, in order: x, y, w, h and colour
// - cfg_ch writes smoothing factor, screen width, screen height, bar count
//   (index 0..3); cfg_ch is always ready, write only while no item is in flight
// - one item per cycle while the two-entry output buffer is not full
// - the rate is set by the level memory read-modify-write, closed by forwarding
//   the previous write; sqrt and both divisions run 4 and 5 digit steps per
//   stage over four stages
// - reset sets the registers to their defaults and clears every stored level
//   through per-bar valid bits, so items are taken in the first cycle after reset
// - a stalled receiver fills the two-entry output buffer; only then does the
//   whole pipeline hold and in_ch.ready drop, nothing is lost or repeated
`include "spectrum_bar_smoother_macros.svh"

module spectrum_bar_smoother import sbs_pkg::*; #(
  parameter int MAX_BARS = MAX_BARS_DEFAULT
) (
  input logic clk,
  input logic rst,
  sbs_in_if.sink in_ch,
  sbs_out_if.source out_ch,
  sbs_cfg_if.sink cfg_ch
);

  localparam int BARS_CAP = (MAX_BARS > 127) ? 127 : MAX_BARS;

  // configuration registers
  logic [15:0] sf;
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [6:0] bar_count;

  logic [12:0] wc;
  logic [12:0] hc;
  logic [6:0] bars;

  // pipeline control
  logic en;
  logic buf_full;

  // stage 1 and the iteration stages
  logic signed [31:0] re_sq;
  logic signed [31:0] im_sq;
  iter_t s1_next;
  logic vst [ITER_STAGES+1];
  iter_t st [ITER_STAGES+1];

  // after the iterations
  logic v6;
  logic v7;
  logic v8;
  logic [IDX_W-1:0] idx6;
  logic [IDX_W-1:0] idx7;
  logic [IDX_W-1:0] idx8;
  logic inr6;
  logic inr7;
  logic inr8;
  logic [11:0] xq6;
  logic [11:0] xq7;
  logic [11:0] xq8;
  logic [12:0] wq6;
  logic [12:0] wq7;
  logic [12:0] wq8;
  logic [16:0] level7;
  logic [29:0] prod8;

  logic [14:0] bh_raw;
  logic [12:0] bh;
  res_t res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf <= SMOOTHING_RESET;
      screen_width <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      bar_count <= BARS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_SMOOTHING: sf <= cfg_ch.data;
        REG_WIDTH: screen_width <= cfg_ch.data[12:0];
        REG_HEIGHT: screen_height <= cfg_ch.data[12:0];
        REG_BARS: bar_count <= cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end

  // oversized screen and bar count are clamped
  always_comb begin
    wc = (screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width;
    hc = (screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height;
    bars = (bar_count > 7'(BARS_CAP)) ? 7'(BARS_CAP) : bar_count;
  end

  // everything advances together; the output buffer absorbs a stall
  assign en = !buf_full;
  assign in_ch.ready = en;

  // stage 1: squares, bar_x and bar_w dividends, in-range check
  always_comb begin
    re_sq = in_ch.real_part * in_ch.real_part;
    im_sq = in_ch.imag_part * in_ch.imag_part;
    s1_next.idx = in_ch.bin_index;
    s1_next.inr = ({1'b0, in_ch.bin_index} < bars);
    s1_next.sq_n = $unsigned(re_sq) + $unsigned(im_sq);
    s1_next.sq_rem = '0;
    s1_next.sq_root = '0;
    s1_next.x_num = 20'(in_ch.bin_index) * 20'(wc);
    s1_next.x_rem = '0;
    s1_next.w_num = 20'(wc);
    s1_next.w_rem = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vst[0] <= 1'b0;
    end else if (en) begin
      vst[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= s1_next;
    end
  end

  // stages 2 to 5: magnitude and both quotients, four root and five quotient digits per stage
  for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
    sbs_iter_stage u_iter (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (vst[g]),
      .d_in    (st[g]),
      .divisor (bars),
      .v_out   (vst[g+1]),
      .d_out   (st[g+1])
    );
  end

  // stages 6 and 7: level read, blend and write back
  sbs_level_store #(
    .MAX_BARS (MAX_BARS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (vst[ITER_STAGES] && st[ITER_STAGES].inr),
    .idx   (st[ITER_STAGES].idx),
    .mag   (st[ITER_STAGES].sq_root),
    .sf    (sf),
    .level (level7)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v6 <= vst[ITER_STAGES];
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx6 <= st[ITER_STAGES].idx;
      inr6 <= st[ITER_STAGES].inr;
      xq6 <= st[ITER_STAGES].x_num[11:0];
      wq6 <= st[ITER_STAGES].w_num[12:0];
      idx7 <= idx6;
      inr7 <= inr6;
      xq7 <= xq6;
      wq7 <= wq6;
      // stage 8: level scaled by screen height in q2.15
      prod8 <= 30'(level7) * 30'(hc);
      idx8 <= idx7;
      inr8 <= inr7;
      xq8 <= xq7;
      wq8 <= wq7;
    end
  end

  // bar height saturates at the screen height; out-of-range gives all zero
  always_comb begin
    bh_raw = prod8[29:15];
    bh = (bh_raw > {2'b00, hc}) ? hc : bh_raw[12:0];
    res = '0;
    res.out_of_range = !inr8;
    if (inr8) begin
      res.bar_x = xq8;
      res.bar_y = hc - bh;
      res.bar_w = wq8;
      res.bar_h = bh;
      res.red = colour(idx8, RED_MUL);
      res.green = colour(idx8, GREEN_MUL);
      res.blue = colour(idx8, BLUE_MUL);
    end
  end

  sbs_out_buf u_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (en && v8),
    .din    (res),
    .full   (buf_full),
    .out_ch (out_ch)
  );

  `SBS_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vst[0])
  `SBS_ASSERT_IMPL(a_full_holds_input, buf_full, !in_ch.ready)
  `SBS_ASSERT_IMPL(a_range_zeroes, out_ch.valid && out_ch.out_of_range, out_ch.bar_h == 13'd0 && out_ch.bar_w == 13'd0 && out_ch.red == 8'd0)

endmodule
